[hw/rtl/rsq_pkg.sv]
// Types, sizes and codes shared by the reservation slot queue.
// Used by rsq_slot_store, rsq_ctrl, the top level and the checker.
package rsq_pkg;

	localparam int SLOTS     = 16;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CLIENT_W  = 16;
	localparam int REQ_W     = 32;
	localparam int STAMP_W   = 32;
	localparam int TIMEOUT_W = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1024;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESERVE = 2'd1,
		OP_SUBMIT  = 2'd2,
		OP_PROCESS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RESP_DONE   = 2'd0,
		RESP_NONE   = 2'd1,
		RESP_REJECT = 2'd2
	} resp_t;

	typedef enum logic [1:0] {
		SLOT_FREE     = 2'd0,
		SLOT_RESERVED = 2'd1,
		SLOT_QUEUED   = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SUB_RD,
		S_SUB_CHK,
		S_DONE
	} rsq_state_t;

	typedef struct packed {
		logic                status_we;
		slot_state_t         status;
		logic                owner_we;
		logic                stamp_we;
		logic                payload_we;
		logic [IDX_W-1:0]    idx;
		logic [CLIENT_W-1:0] owner;
		logic [STAMP_W-1:0]  stamp;
		logic [REQ_W-1:0]    payload;
	} rsq_wr_t;

	typedef struct packed {
		slot_state_t         status;
		logic [CLIENT_W-1:0] owner;
		logic [STAMP_W-1:0]  stamp;
		logic [REQ_W-1:0]    payload;
	} rsq_rd_t;

endpackage

[hw/rtl/rsq_slot_store.sv]
// Slot state flops and the owner, stamp and payload memories of the ring.
// One write and one registered read per cycle; depends on rsq_pkg.
module rsq_slot_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rsq_pkg::IDX_W-1:0] rd_addr,
	input  rsq_pkg::rsq_wr_t         wr,
	output rsq_pkg::rsq_rd_t         rd
);
	import rsq_pkg::*;

	slot_state_t         status_q [SLOTS];
	logic [CLIENT_W-1:0] owner_mem [SLOTS];
	logic [STAMP_W-1:0]  stamp_mem [SLOTS];
	logic [REQ_W-1:0]    payload_mem [SLOTS];
	logic [IDX_W-1:0]    rd_idx_q;
	logic [CLIENT_W-1:0] owner_rd_q;
	logic [STAMP_W-1:0]  stamp_rd_q;
	logic [REQ_W-1:0]    payload_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= SLOT_FREE;
			end
			rd_idx_q <= '0;
		end else begin
			if (wr.status_we) begin
				status_q[wr.idx] <= wr.status;
			end
			rd_idx_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.owner_we) begin
			owner_mem[wr.idx] <= wr.owner;
		end
		if (wr.stamp_we) begin
			stamp_mem[wr.idx] <= wr.stamp;
		end
		if (wr.payload_we) begin
			payload_mem[wr.idx] <= wr.payload;
		end
		owner_rd_q   <= owner_mem[rd_addr];
		stamp_rd_q   <= stamp_mem[rd_addr];
		payload_rd_q <= payload_mem[rd_addr];
	end

	assign rd.status  = status_q[rd_idx_q];
	assign rd.owner   = owner_rd_q;
	assign rd.stamp   = stamp_rd_q;
	assign rd.payload = payload_rd_q;

endmodule

[hw/rtl/rsq_ctrl.sv]
// Sequencer of the slot queue: ring scan, age compare, head and tick count.
// Drives rsq_slot_store and holds the result; depends on rsq_pkg.
module rsq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    op,
	input  logic [3:0]                    slot,
	input  logic [rsq_pkg::CLIENT_W-1:0]  client_id,
	input  logic [rsq_pkg::REQ_W-1:0]     request_word,
	input  logic [rsq_pkg::TIMEOUT_W-1:0] timeout,
	input  rsq_pkg::rsq_rd_t              rd,
	input  logic                          res_take,
	output logic                          idle,
	output logic [rsq_pkg::IDX_W-1:0]     rd_addr,
	output rsq_pkg::rsq_wr_t              wr,
	output logic                          res_valid,
	output logic [1:0]                    res_status,
	output logic [3:0]                    res_idx,
	output logic [rsq_pkg::CLIENT_W-1:0]  res_client,
	output logic [rsq_pkg::REQ_W-1:0]     res_req
);
	import rsq_pkg::*;

	rsq_state_t          state_q, state_d;
	op_t                 op_q;
	logic [3:0]          slot_q;
	logic [CLIENT_W-1:0] client_q;
	logic [REQ_W-1:0]    req_q;
	logic [IDX_W-1:0]    head_q;
	logic [STAMP_W-1:0]  now_q;
	logic [CNT_W-1:0]    k_q;
	logic                eval_vld_s1;
	logic [IDX_W-1:0]    eval_idx_s1;
	resp_t               res_status_q;
	logic [3:0]          res_idx_q;
	logic [CLIENT_W-1:0] res_client_q;
	logic [REQ_W-1:0]    res_req_q;

	logic                issue;
	logic [IDX_W:0]      scan_sum;
	logic [IDX_W-1:0]    scan_idx;
	logic [STAMP_W-1:0]  age;
	logic                expired;
	logic                hit;
	logic                found;
	logic                miss;
	logic                slot_in_range;
	logic                submit_ok;

	assign issue    = (state_q == S_SCAN) && (k_q < CNT_W'(SLOTS));
	assign scan_sum = {1'b0, head_q} + (IDX_W + 1)'(k_q[IDX_W-1:0]);
	assign scan_idx = (scan_sum >= (IDX_W + 1)'(SLOTS)) ?
		IDX_W'(scan_sum - (IDX_W + 1)'(SLOTS)) : IDX_W'(scan_sum);
	assign rd_addr  = (state_q == S_SUB_RD) ? IDX_W'(slot_q) : scan_idx;

	assign age     = now_q - rd.stamp;
	assign expired = age >= STAMP_W'(timeout);

	always_comb begin
		case (op_q)
			OP_RESERVE: hit = (rd.status == SLOT_FREE) ||
				((rd.status == SLOT_RESERVED) && expired);
			OP_PROCESS: hit = (rd.status == SLOT_QUEUED);
			default:    hit = 1'b0;
		endcase
	end

	assign found = (state_q == S_SCAN) && eval_vld_s1 && hit;
	assign miss  = (state_q == S_SCAN) && eval_vld_s1 && !hit && !issue;

	assign slot_in_range = 32'(slot_q) < 32'(SLOTS);
	assign submit_ok     = slot_in_range && (rd.status == SLOT_RESERVED) &&
		(rd.owner == client_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op_t'(op))
						OP_TICK:   state_d = S_DONE;
						OP_SUBMIT: state_d = S_SUB_RD;
						default:   state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				if (found || miss) begin
					state_d = S_DONE;
				end
			end
			S_SUB_RD:  state_d = S_SUB_CHK;
			S_SUB_CHK: state_d = S_DONE;
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		wr            = '0;
		wr.status     = SLOT_FREE;
		wr.idx        = eval_idx_s1;
		wr.owner      = client_q;
		wr.stamp      = now_q;
		wr.payload    = req_q;
		if (found && op_q == OP_RESERVE) begin
			wr.status_we = 1'b1;
			wr.status    = SLOT_RESERVED;
			wr.owner_we  = 1'b1;
			wr.stamp_we  = 1'b1;
		end else if (found) begin
			wr.status_we = 1'b1;
			wr.status    = SLOT_FREE;
		end else if (state_q == S_SUB_CHK && submit_ok) begin
			wr.status_we  = 1'b1;
			wr.status     = SLOT_QUEUED;
			wr.payload_we = 1'b1;
			wr.idx        = IDX_W'(slot_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			now_q       <= '0;
			k_q         <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				k_q         <= '0;
				eval_vld_s1 <= 1'b0;
				if (op_t'(op) == OP_TICK) begin
					now_q <= now_q + STAMP_W'(1);
				end
			end else if (issue) begin
				k_q         <= k_q + CNT_W'(1);
				eval_vld_s1 <= 1'b1;
			end else begin
				eval_vld_s1 <= 1'b0;
			end
			if (found && op_q == OP_PROCESS) begin
				head_q <= eval_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q         <= op_t'(op);
			slot_q       <= slot;
			client_q     <= client_id;
			req_q        <= request_word;
			res_status_q <= RESP_DONE;
			res_idx_q    <= '0;
			res_client_q <= '0;
			res_req_q    <= '0;
		end
		if (issue) begin
			eval_idx_s1 <= scan_idx;
		end
		if (found) begin
			res_status_q <= RESP_DONE;
			res_idx_q    <= 4'(eval_idx_s1);
			if (op_q == OP_PROCESS) begin
				res_client_q <= rd.owner;
				res_req_q    <= rd.payload;
			end
		end else if (miss) begin
			res_status_q <= RESP_NONE;
		end
		if (state_q == S_SUB_CHK) begin
			res_status_q <= submit_ok ? RESP_DONE : RESP_REJECT;
			res_idx_q    <= slot_q;
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_status = res_status_q;
	assign res_idx    = res_idx_q;
	assign res_client = res_client_q;
	assign res_req    = res_req_q;

endmodule

[hw/rtl/reservation_slot_queue_core.sv]
// Reservation slot queue: a ring of slots that clients reserve, fill with a request, and
// that process calls serve in ring order. One transaction is taken at a time; a reserve
// or process scan walks the ring from the head one slot per cycle through the single
// read port of the slot memories, and the result then sits in an output register while
// the next transaction is taken. reserve_timeout is written through cfg_we / cfg_wdata;
// the user must write it only while the block is idle, as the block does not enforce it.
// Depends on rsq_pkg, rsq_slot_store, rsq_ctrl.
module reservation_slot_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [3:0]                    slot,
	input  logic [rsq_pkg::CLIENT_W-1:0]  client_id,
	input  logic [rsq_pkg::REQ_W-1:0]     request_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [3:0]                    slot_index,
	output logic [rsq_pkg::CLIENT_W-1:0]  served_client,
	output logic [rsq_pkg::REQ_W-1:0]     served_request,
	input  logic                          cfg_we,
	input  logic [rsq_pkg::TIMEOUT_W-1:0] cfg_wdata
);
	import rsq_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 idle;
	logic                 start;
	logic                 res_valid;
	logic                 res_take;
	logic [1:0]           res_status;
	logic [3:0]           res_idx;
	logic [CLIENT_W-1:0]  res_client;
	logic [REQ_W-1:0]     res_req;
	logic [IDX_W-1:0]     rd_addr;
	rsq_wr_t              wr;
	rsq_rd_t              rd;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [3:0]           slot_index_q;
	logic [CLIENT_W-1:0]  served_client_q;
	logic [REQ_W-1:0]     served_request_q;

	assign in_stall = !idle;
	assign start    = in_valid && !in_stall;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	rsq_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

	rsq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.slot         (slot),
		.client_id    (client_id),
		.request_word (request_word),
		.timeout      (timeout_q),
		.rd           (rd),
		.res_take     (res_take),
		.idle         (idle),
		.rd_addr      (rd_addr),
		.wr           (wr),
		.res_valid    (res_valid),
		.res_status   (res_status),
		.res_idx      (res_idx),
		.res_client   (res_client),
		.res_req      (res_req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q         <= res_status;
			slot_index_q     <= res_idx;
			served_client_q  <= res_client;
			served_request_q <= res_req;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign slot_index     = slot_index_q;
	assign served_client  = served_client_q;
	assign served_request = served_request_q;

endmodule

[hw/rtl/rsq_checker.sv]
// Port-level checks of the reservation slot queue, bound to the top level.
// Depends on rsq_pkg for the status codes.
module rsq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [3:0]                   slot_index,
	input logic [rsq_pkg::CLIENT_W-1:0] served_client,
	input logic [rsq_pkg::REQ_W-1:0]    served_request
);
	import rsq_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
			&& $stable(served_client) && $stable(served_request))
		else $error("stalled result changed");

	a_served_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != RESP_DONE |-> served_client == '0 && served_request == '0)
		else $error("served fields set on a failed transaction");

endmodule

bind reservation_slot_queue_core rsq_checker u_rsq_checker (.*);

[tb/sv/reservation_slot_queue_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for reservation_slot_queue_core: directed table, then random phases.
// Keeps its own slot-ring predictor and checks every result transaction in order.
// Depends on rsq_pkg and the core RTL only.
module reservation_slot_queue_core_tb;
	import rsq_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PLAN_ROWS = 19;
	localparam int N_PHASES = 6;

	typedef struct packed {
		resp_t               status;
		logic [3:0]          slot;
		logic [CLIENT_W-1:0] client;
		logic [REQ_W-1:0]    request;
	} reply_t;

	typedef enum logic {ROW_TXN, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		op_t                 op;
		logic [3:0]          slot;
		logic [CLIENT_W-1:0] client;
		logic [REQ_W-1:0]    req;
		logic [4:0]          reps;
		logic                typed;
		reply_t              want;
	} plan_row_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout;
		logic [6:0]           tx_idle;
		logic [6:0]           rx_stall;
		logic [15:0]          items;
	} phase_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           op;
	logic [3:0]           slot;
	logic [CLIENT_W-1:0]  client_id;
	logic [REQ_W-1:0]     request_word;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic [3:0]           slot_index;
	logic [CLIENT_W-1:0]  served_client;
	logic [REQ_W-1:0]     served_request;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	slot_state_t          ring_state [SLOTS];
	logic [CLIENT_W-1:0]  ring_owner [SLOTS];
	logic [REQ_W-1:0]     ring_payload [SLOTS];
	logic [STAMP_W-1:0]   ring_stamp [SLOTS];
	int                   ring_head;
	logic [STAMP_W-1:0]   tick_count;
	logic [TIMEOUT_W-1:0] timeout_ticks;

	reply_t      replies_due [$];
	int          err_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          rx_hold_start = 1'b0;
	int unsigned idle_run = 0;

	// client field of a ROW_CFG row carries the timeout value
	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{ROW_TXN, OP_PROCESS, 0, 0, 0, 1, 1, '{RESP_NONE, 0, 0, 0}},
		'{ROW_TXN, OP_TICK, 0, 0, 0, 1, 1, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 15, 'hFFFF, 'hFFFF_FFFF, 1, 1, '{RESP_REJECT, 15, 0, 0}},
		'{ROW_TXN, OP_RESERVE, 0, 'hFFFF, 0, 16, 0, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_RESERVE, 0, 0, 0, 1, 1, '{RESP_NONE, 0, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 0, 0, 0, 1, 1, '{RESP_REJECT, 0, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 0, 'hFFFF, 'hFFFF_FFFF, 1, 1, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 0, 'hFFFF, 0, 1, 1, '{RESP_REJECT, 0, 0, 0}},
		'{ROW_TXN, OP_PROCESS, 0, 0, 0, 1, 1, '{RESP_DONE, 0, 'hFFFF, 'hFFFF_FFFF}},
		'{ROW_CFG, OP_TICK, 0, 1, 0, 0, 0, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_TICK, 0, 0, 0, 1, 1, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 3, 'hFFFF, 0, 1, 1, '{RESP_DONE, 3, 0, 0}},
		'{ROW_TXN, OP_RESERVE, 0, 0, 0, 1, 1, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_RESERVE, 0, 'h8001, 0, 1, 1, '{RESP_DONE, 1, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 1, 'hFFFF, 0, 1, 1, '{RESP_REJECT, 1, 0, 0}},
		'{ROW_TXN, OP_SUBMIT, 1, 'h8001, 'hA5A5_A5A5, 1, 0, '{RESP_DONE, 0, 0, 0}},
		'{ROW_TXN, OP_PROCESS, 0, 0, 0, 1, 1, '{RESP_DONE, 1, 'h8001, 'hA5A5_A5A5}},
		'{ROW_TXN, OP_PROCESS, 0, 0, 0, 1, 1, '{RESP_DONE, 3, 'hFFFF, 0}},
		'{ROW_TXN, OP_PROCESS, 0, 0, 0, 1, 1, '{RESP_NONE, 0, 0, 0}}
	};

	phase_t test_phases [N_PHASES] = '{
		'{16'd65535, 0, 0, 300},
		'{16'd1, 55, 0, 300},
		'{16'd3, 0, 55, 300},
		'{16'd1024, 20, 20, 300},
		'{16'd40, 55, 55, 300},
		'{16'd12, 0, 0, 300}
	};

	reservation_slot_queue_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.slot           (slot),
		.client_id      (client_id),
		.request_word   (request_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot_index     (slot_index),
		.served_client  (served_client),
		.served_request (served_request),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void note_failure(string what);
		err_count++;
		if (err_count <= 10) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endfunction

	function automatic reply_t slot_queue_reply(op_t o, logic [3:0] s,
			logic [CLIENT_W-1:0] c, logic [REQ_W-1:0] r);
		reply_t y;
		int n;
		int start;
		logic [STAMP_W-1:0] age;
		bit found;
		y = '0;
		found = 1'b0;
		start = ring_head;
		case (o)
		OP_TICK: tick_count = tick_count + 1'b1;
		OP_RESERVE: begin
			y.status = RESP_NONE;
			for (int k = 0; k < SLOTS; k++) begin
				n = (start + k) % SLOTS;
				age = tick_count - ring_stamp[n];
				if (!found && (ring_state[n] == SLOT_FREE ||
						(ring_state[n] == SLOT_RESERVED && age >= timeout_ticks))) begin
					found = 1'b1;
					ring_state[n] = SLOT_RESERVED;
					ring_owner[n] = c;
					ring_stamp[n] = tick_count;
					y.status = RESP_DONE;
					y.slot = 4'(n);
				end
			end
		end
		OP_SUBMIT: begin
			y.slot = s;
			if (int'(s) < SLOTS && ring_state[s] == SLOT_RESERVED && ring_owner[s] == c) begin
				ring_state[s] = SLOT_QUEUED;
				ring_payload[s] = r;
			end else begin
				y.status = RESP_REJECT;
			end
		end
		OP_PROCESS: begin
			y.status = RESP_NONE;
			for (int k = 0; k < SLOTS; k++) begin
				n = (start + k) % SLOTS;
				if (!found && ring_state[n] == SLOT_QUEUED) begin
					found = 1'b1;
					ring_head = n;
					y.status = RESP_DONE;
					y.slot = 4'(n);
					y.client = ring_owner[n];
					y.request = ring_payload[n];
					ring_state[n] = SLOT_FREE;
				end
			end
		end
		endcase
		return y;
	endfunction

	task automatic offer_txn(op_t o, logic [3:0] s, logic [CLIENT_W-1:0] c,
			logic [REQ_W-1:0] r, logic typed, reply_t want);
		int gap;
		reply_t fresh;
		gap = 0;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 8);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		slot <= s;
		client_id <= c;
		request_word <= r;
		do @(posedge clk); while (in_stall);
		fresh = slot_queue_reply(o, s, c, r);
		replies_due.push_back(typed ? want : fresh);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
		drain_replies();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_ticks = value;
	endtask

	initial begin
		plan_row_t row;
		phase_t ph;
		op_t o;
		logic [3:0] rs;
		logic [CLIENT_W-1:0] rc;
		logic [REQ_W-1:0] rr;
		int pick;
		int held [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		slot = '0;
		client_id = '0;
		request_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int n = 0; n < SLOTS; n++) begin
			ring_state[n] = SLOT_FREE;
			ring_owner[n] = '0;
			ring_payload[n] = '0;
			ring_stamp[n] = '0;
		end
		ring_head = 0;
		tick_count = '0;
		timeout_ticks = TIMEOUT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_stall_pct = 20;
		for (int p = 0; p < PLAN_ROWS; p++) begin
			row = directed_plan[p];
			if (row.kind == ROW_CFG) begin
				set_timeout(row.client);
			end else begin
				repeat (row.reps) offer_txn(row.op, row.slot, row.client, row.req, row.typed, row.want);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			ph = test_phases[p];
			set_timeout(ph.timeout);
			tx_idle_pct = ph.tx_idle;
			rx_stall_pct = ph.rx_stall;
			for (int i = 0; i < ph.items; i++) begin
				if (p == 0 && i == 100) begin
					rx_hold_start = 1'b1;
				end
				if (p == 3 && i == 150) begin
					drain_replies();
				end
				pick = $urandom_range(99);
				rs = 4'($urandom_range(15));
				rr = $urandom;
				if ($urandom_range(99) < 60) begin
					rc = CLIENT_W'($urandom_range(3));
				end else begin
					rc = CLIENT_W'($urandom_range(16'hFFFF));
				end
				if (pick < 25) begin
					o = OP_TICK;
				end else if (pick < 55) begin
					o = OP_RESERVE;
				end else if (pick < 80) begin
					o = OP_SUBMIT;
					held.delete();
					for (int n = 0; n < SLOTS; n++) begin
						if (ring_state[n] == SLOT_RESERVED) begin
							held.push_back(n);
						end
					end
					if (held.size() != 0 && $urandom_range(99) < 80) begin
						rs = 4'(held[$urandom_range(held.size() - 1)]);
						rc = ring_owner[rs];
						if ($urandom_range(99) < 10) begin
							rc = rc ^ 16'h0001;
						end
					end
				end else begin
					o = OP_PROCESS;
				end
				offer_txn(o, rs, rc, rr, 1'b0, '0);
			end
		end

		drain_replies();
		repeat (40) @(posedge clk);
		if (replies_due.size() != 0) begin
			note_failure("results still due at end of run");
		end
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		int left;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_start) begin
				left = HOLD_CYCLES;
				rx_hold_start = 1'b0;
			end
			if (left != 0) begin
				left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		reply_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				note_failure($sformatf("unexpected result status %0d slot %0d client %h request %h",
					status, slot_index, served_client, served_request));
			end else begin
				due = replies_due.pop_front();
				if (status !== due.status || slot_index !== due.slot ||
						served_client !== due.client || served_request !== due.request) begin
					note_failure($sformatf("exp %0d/%0d/%h/%h got %0d/%0d/%h/%h",
						due.status, due.slot, due.client, due.request,
						status, slot_index, served_client, served_request));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

endmodule
